// ===== hdl/pixel_cursor_shadow_store_assert.svh =====
// Assertion macros shared by the shadow store RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef PIXEL_CURSOR_SHADOW_STORE_ASSERT_SVH
`define PIXEL_CURSOR_SHADOW_STORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge outside reset
`define PCSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define PCSS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PCSS_ASSERT(lbl, prop, msg)
`define PCSS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hdl/pcss_pkg.sv =====
package pcss_pkg;

	// request kind codes
	localparam logic [1:0] KIND_DRAW  = 2'd0;
	localparam logic [1:0] KIND_KEEP  = 2'd1;
	localparam logic [1:0] KIND_FRAME = 2'd2;

	localparam int RGB_W   = 24;
	localparam int RUN_W   = 16;
	localparam int COORD_W = 8;

	// what a request produces once it has passed the cursor
	typedef enum logic [2:0] {
		RES_NONE = 3'b001,
		RES_DRAW = 3'b010,
		RES_KEEP = 3'b100
	} res_t;

	// shadow memory access strobes
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

// ===== hdl/pcss_shadow_mem.sv =====
`include "pixel_cursor_shadow_store_assert.svh"

module pcss_shadow_mem import pcss_pkg::*; #(
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_ctl_t          ctl,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [RGB_W-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [RGB_W-1:0]  rd_data,
	output logic              ready
);

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	logic [RGB_W-1:0]  mem [DEPTH];
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// clearing pass after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign ready = !clearing_q;

	`PCSS_ASSERT(a_no_wr_in_clear, ctl.wr_en |-> !clearing_q, "write during clearing pass")
	`PCSS_ASSERT(a_no_rd_in_clear, ctl.rd_en |-> !clearing_q, "read during clearing pass")
	`PCSS_ASSERT(a_clear_full, $fell(clearing_q) |-> $past(clr_addr_q) == LAST_ADDR, "clear cut short")

endmodule

// ===== hdl/pixel_cursor_shadow_store.sv =====
// out_valid rises once the request has passed the 7 pipeline registers (s1 to s7),
// the first loaded on the accepting edge.
// Throughput: one request per cycle unless out_ready or the memory clear stalls input;
// the cursor updates in a single stage, which also reads and writes the shadow memory,
// so no request waits on another. Reset: cursor returns to the origin and the shadow
// memory is swept to zero, one entry per cycle, over every entry while in_ready stays low.
`include "pixel_cursor_shadow_store_assert.svh"

module pixel_cursor_shadow_store import pcss_pkg::*; #(
	parameter int PANEL_WIDTH  = 64,
	parameter int PANEL_HEIGHT = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic [15:0] run_length,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       display_write,
	output logic [5:0] column,
	output logic [4:0] row,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic       color_valid
);

	localparam int FRAME = PANEL_WIDTH * PANEL_HEIGHT;
	localparam int POS_W = (FRAME > 1) ? $clog2(FRAME) : 1;
	localparam int PROD_F_W = RUN_W + 33;
	localparam int PROD_W_W = COORD_W + 33;

	// reciprocals scaled by 2^32, quotient may come out one low
	localparam logic [32:0] RECIP_F = 33'((64'd1 << 32) / FRAME);
	localparam logic [32:0] RECIP_W = 33'((64'd1 << 32) / PANEL_WIDTH);

	localparam logic [RUN_W-1:0]   FRAME_R  = RUN_W'(FRAME);
	localparam logic [POS_W:0]     FRAME_P  = (POS_W + 1)'(FRAME);
	localparam logic [POS_W-1:0]   LAST_POS = POS_W'(FRAME - 1);
	localparam logic [COORD_W-1:0] WIDTH_C  = COORD_W'(PANEL_WIDTH);

	logic advance;
	logic accept;
	logic mem_ready;

	// stage 1: run length times frame reciprocal
	logic                valid_s1;
	logic [1:0]          kind_s1;
	logic [RGB_W-1:0]    rgb_s1;
	logic [RUN_W-1:0]    run_s1;
	logic [PROD_F_W-1:0] prod_s1;

	// stage 2: quotient times frame size
	logic             valid_s2;
	logic [1:0]       kind_s2;
	logic [RGB_W-1:0] rgb_s2;
	logic [RUN_W-1:0] run_s2;
	logic [RUN_W-1:0] qf_s2;

	// stage 3: run length modulo frame size
	logic             valid_s3;
	logic [1:0]       kind_s3;
	logic [RGB_W-1:0] rgb_s3;
	logic [POS_W-1:0] runm_s3;
	logic             run_nz_s3;
	logic [RUN_W-1:0] rem_raw;

	// cursor stage
	logic [POS_W-1:0] pos_q;
	res_t             op_c;
	logic [POS_W:0]   keep_sum;
	logic [POS_W-1:0] keep_next;
	logic [POS_W-1:0] keep_last;
	logic [POS_W-1:0] draw_next;
	logic [POS_W-1:0] addr_c;
	mem_ctl_t         mem_ctl;
	logic [RGB_W-1:0] rd_data;

	logic             valid_s4;
	res_t             op_s4;
	logic [POS_W-1:0] addr_s4;
	logic [RGB_W-1:0] rgb_s4;

	// stage 5: address times width reciprocal
	logic                valid_s5;
	res_t                op_s5;
	logic [POS_W-1:0]    addr_s5;
	logic [RGB_W-1:0]    color_s5;
	logic [PROD_W_W-1:0] prod_s5;

	// stage 6: row estimate times width
	logic               valid_s6;
	res_t               op_s6;
	logic [POS_W-1:0]   addr_s6;
	logic [RGB_W-1:0]   color_s6;
	logic [COORD_W-1:0] q_s6;
	logic [POS_W-1:0]   qw_s6;

	// stage 7: output register
	logic             valid_s7;
	logic             write_s7;
	logic             cvalid_s7;
	logic [5:0]       col_s7;
	logic [4:0]       row_s7;
	logic [RGB_W-1:0] color_s7;
	logic [POS_W-1:0] col_raw;
	logic             col_over;
	logic [COORD_W-1:0] col_c;
	logic [COORD_W-1:0] row_c;

	assign advance  = !valid_s7 || out_ready;
	assign in_ready = advance && mem_ready;
	assign accept   = in_valid && in_ready;

	// run modulo frame: remainder of estimate, one correction
	assign rem_raw = run_s2 - qf_s2;

	// cursor stage decode
	always_comb begin
		unique case (kind_s3)
			KIND_DRAW: op_c = RES_DRAW;
			KIND_KEEP: op_c = run_nz_s3 ? RES_KEEP : RES_NONE;
			default:   op_c = RES_NONE;
		endcase
	end

	// next cursor and last kept pixel
	always_comb begin
		keep_sum  = {1'b0, pos_q} + {1'b0, runm_s3};
		keep_next = (keep_sum >= FRAME_P) ? POS_W'(keep_sum - FRAME_P) : POS_W'(keep_sum);
		keep_last = (keep_next == '0) ? LAST_POS : keep_next - 1'b1;
		draw_next = (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
		addr_c    = (op_c == RES_KEEP) ? keep_last : pos_q;
	end

	// write and read share the cursor stage, so no overlap between requests
	assign mem_ctl.wr_en = advance && valid_s3 && (op_c == RES_DRAW);
	assign mem_ctl.rd_en = advance && valid_s3 && (op_c == RES_KEEP);

	pcss_shadow_mem #(
		.DEPTH (FRAME),
		.ADDR_W(POS_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mem_ctl),
		.wr_addr(pos_q),
		.wr_data(rgb_s3),
		.rd_addr(keep_last),
		.rd_data(rd_data),
		.ready  (mem_ready)
	);

	// column split: remainder of estimate, one correction
	always_comb begin
		col_raw  = addr_s6 - qw_s6;
		col_over = 16'(col_raw) >= 16'(PANEL_WIDTH);
		col_c    = col_over ? COORD_W'(16'(col_raw) - 16'(PANEL_WIDTH)) : COORD_W'(col_raw);
		row_c    = col_over ? q_s6 + 1'b1 : q_s6;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			pos_q    <= '0;
		end else if (advance) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			if (valid_s3) begin
				if (op_c == RES_DRAW) begin
					pos_q <= draw_next;
				end else if (op_c == RES_KEEP) begin
					pos_q <= keep_next;
				end else if (kind_s3 == KIND_FRAME) begin
					pos_q <= '0;
				end
			end
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s1 <= kind;
			rgb_s1  <= {red_in, green_in, blue_in};
			run_s1  <= run_length;
			prod_s1 <= PROD_F_W'(run_length) * PROD_F_W'(RECIP_F);

			kind_s2 <= kind_s1;
			rgb_s2  <= rgb_s1;
			run_s2  <= run_s1;
			qf_s2   <= RUN_W'(prod_s1[32 +: RUN_W] * FRAME_R);

			kind_s3   <= kind_s2;
			rgb_s3    <= rgb_s2;
			run_nz_s3 <= (run_s2 != '0);
			runm_s3   <= (rem_raw >= FRAME_R) ? POS_W'(rem_raw - FRAME_R) : POS_W'(rem_raw);

			op_s4   <= op_c;
			addr_s4 <= addr_c;
			rgb_s4  <= rgb_s3;

			op_s5    <= op_s4;
			addr_s5  <= addr_s4;
			color_s5 <= (op_s4 == RES_KEEP) ? rd_data : rgb_s4;
			prod_s5  <= PROD_W_W'(addr_s4) * PROD_W_W'(RECIP_W);

			op_s6    <= op_s5;
			addr_s6  <= addr_s5;
			color_s6 <= color_s5;
			q_s6     <= prod_s5[32 +: COORD_W];
			qw_s6    <= POS_W'(16'(prod_s5[32 +: COORD_W]) * 16'(WIDTH_C));

			write_s7  <= (op_s6 == RES_DRAW);
			cvalid_s7 <= (op_s6 == RES_KEEP);
			col_s7    <= (op_s6 == RES_NONE) ? '0 : col_c[5:0];
			row_s7    <= (op_s6 == RES_NONE) ? '0 : row_c[4:0];
			color_s7  <= (op_s6 == RES_NONE) ? '0 : color_s6;
		end
	end

	assign out_valid     = valid_s7;
	assign display_write = write_s7;
	assign color_valid   = cvalid_s7;
	assign column        = col_s7;
	assign row           = row_s7;
	assign red_out       = color_s7[23:16];
	assign green_out     = color_s7[15:8];
	assign blue_out      = color_s7[7:0];

	`PCSS_ASSERT(a_pos_range, (POS_W + 1)'(pos_q) < FRAME_P, "cursor outside frame")
	`PCSS_ASSERT(a_draw_step, (advance && valid_s3 && op_c == RES_DRAW && pos_q != LAST_POS) |=> pos_q == $past(pos_q) + 1'b1, "draw did not advance cursor")
	`PCSS_ASSERT(a_frame_home, (advance && valid_s3 && kind_s3 == KIND_FRAME) |=> pos_q == '0, "frame start missed origin")

endmodule
